>>> hdl/differential_drive_odometry_assert.svh
// Assertion macros for the odometry block
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define DDO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Types and constants shared by the odometry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int unsigned AtanEntries = 30;
  localparam int unsigned PositionWidth = 48;
  localparam logic signed [33:0] TwoPiQ   = 34'sd1686629713;
  localparam logic signed [33:0] PiQ      = 34'sd843314856;
  localparam logic signed [33:0] HalfPiQ  = 34'sd421657428;
  localparam logic signed [33:0] CordicGainQ = 34'sd652032874;

  // register indexes
  localparam logic [1:0] RegLeftGain  = 2'd0;
  localparam logic [1:0] RegRightGain = 2'd1;
  localparam logic [1:0] RegInvBase   = 2'd2;
  localparam logic [1:0] RegTickLimit = 2'd3;

  typedef struct packed {
    logic [15:0] left_count;
    logic [15:0] right_count;
  } in_item_t;

  // pose item, fields in output order
  typedef struct packed {
    logic signed [PositionWidth-1:0] x_position;
    logic signed [PositionWidth-1:0] y_position;
    logic signed [31:0]              heading;
    logic signed [31:0]              heading_change;
    logic                            ticks_implausible;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DELTA, ST_SCALE_L, ST_SCALE_R, ST_DIST, ST_TURN, ST_HEAD,
    ST_WRAP, ST_FOLD, ST_CORDIC, ST_MUL_C, ST_MUL_S, ST_ACC, ST_OUT
  } state_e;

  // atan(2^-i) in Q5.28
  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      case (i)
        5'd0: r = 34'sd210828714;  5'd1: r = 34'sd124459457;
        5'd2: r = 34'sd65760959;   5'd3: r = 34'sd33381290;
        5'd4: r = 34'sd16755422;   5'd5: r = 34'sd8385879;
        5'd6: r = 34'sd4193963;    5'd7: r = 34'sd2097109;
        5'd8: r = 34'sd1048571;    5'd9: r = 34'sd524287;
        5'd10: r = 34'sd262144;    5'd11: r = 34'sd131072;
        5'd12: r = 34'sd65536;     5'd13: r = 34'sd32768;
        5'd14: r = 34'sd16384;     5'd15: r = 34'sd8192;
        5'd16: r = 34'sd4096;      5'd17: r = 34'sd2048;
        5'd18: r = 34'sd1024;      5'd19: r = 34'sd512;
        5'd20: r = 34'sd256;       5'd21: r = 34'sd128;
        5'd22: r = 34'sd64;        5'd23: r = 34'sd32;
        5'd24: r = 34'sd16;        5'd25: r = 34'sd8;
        5'd26: r = 34'sd4;         5'd27: r = 34'sd2;
        5'd28: r = 34'sd1;         5'd29: r = 34'sd1;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> hdl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning odometry from wheel encoder counts, with an iterative
// CORDIC and a shared multiplier under one sequencer.
// ----------------------------------------------------------------------------
// Channel | Signals                      | Direction
// in      | in_valid_i in_ready_o in_i   | encoder counts in
// out     | out_valid_o out_ready_i out_o| pose item out
// cfg     | psel penable pwrite paddr .. | APB register port
// An item taken passes through the delta, scale, distance, turn, heading, wrap,
// fold, CORDIC, two projection products, accumulate and output steps; each of
// the five products takes two passes on the shared 21x34 multiplier.
// A new item is taken only after the previous result has been taken.
// in_ready_o is high only when idle and no result waits.
// Reset clears pose state and loads the register defaults.
// A stalled output holds the sequencer until the item is taken.
`timescale 1ns / 1ps
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS   = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ddo_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ddo_pkg::out_item_t out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ddo_pkg::*;

  localparam int unsigned PW = PositionWidth;

  // configuration registers
  logic [23:0] lgain_q, rgain_q, invb_q;
  logic [14:0] tlim_q;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lgain_q <= 24'd294337; rgain_q <= 24'd294337;
      invb_q <= 24'd1677722; tlim_q <= 15'd1000;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        RegLeftGain:  lgain_q <= pwdata[23:0];
        RegRightGain: rgain_q <= pwdata[23:0];
        RegInvBase:   invb_q  <= pwdata[23:0];
        RegTickLimit: tlim_q  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegLeftGain:  prdata = {8'd0, lgain_q};
      RegRightGain: prdata = {8'd0, rgain_q};
      RegInvBase:   prdata = {8'd0, invb_q};
      RegTickLimit: prdata = {17'd0, tlim_q};
      default:      prdata = '0;
    endcase
  end

  // pose state and working registers
  state_e st_q, st_d;
  logic first_q;
  logic [15:0] lastl_q, lastr_q;
  logic signed [31:0] head_q;
  logic signed [PW-1:0] x_q, y_q;
  logic signed [16:0] lt_q, rt_q;
  logic signed [41:0] li_q, ri_q, dist_q;
  logic signed [33:0] ang_q, cos_q, sin_q;
  logic neg_q, flag_q;
  logic signed [31:0] chg_q;
  logic signed [PW+1:0] dy_q, dx_q;
  logic ovalid_q;

  // shared multiplier: magnitude 42 x 34 in two 21 x 34 passes, low half
  // first, then a truncating shift toward zero
  logic signed [41:0] ma;
  logic signed [33:0] mb;
  logic [5:0] msh;
  logic mul_on;
  logic mph_q;
  logic [20:0] mpart;
  logic [54:0] mp, plo_q;
  logic [41:0] ua;
  logic [33:0] ub;
  logic [75:0] up;
  logic [75:0] us;
  logic signed [76:0] mres;
  assign ua = ma[41] ? 42'(-ma) : 42'(ma);
  assign ub = mb[33] ? 34'(-mb) : 34'(mb);
  assign mpart = mph_q ? ua[41:21] : ua[20:0];
  assign mp = mpart * ub;
  assign up = {mp, 21'd0} + {21'd0, plo_q};
  assign us = up >> msh;
  assign mres = (ma[41] ^ mb[33]) ? -$signed({1'b0, us}) : $signed({1'b0, us});

  always_comb begin
    ma = '0; mb = '0; msh = '0; mul_on = 1'b0;
    case (st_q)
      ST_SCALE_L: begin
        ma = 42'(lt_q); mb = $signed({10'd0, lgain_q}); mul_on = 1'b1;
      end
      ST_SCALE_R: begin
        ma = 42'(rt_q); mb = $signed({10'd0, rgain_q}); mul_on = 1'b1;
      end
      ST_TURN: begin
        ma = li_q - ri_q; mb = $signed({10'd0, invb_q}); msh = 6'd20; mul_on = 1'b1;
      end
      ST_MUL_C: begin ma = dist_q; mb = cos_q; msh = 6'd38; mul_on = 1'b1; end
      ST_MUL_S: begin ma = dist_q; mb = sin_q; msh = 6'd38; mul_on = 1'b1; end
      default: ;
    endcase
  end

  // heading wrap and quadrant fold
  logic signed [76:0] mhsat;
  logic signed [33:0] hsum, hw1, hw2, afold;
  assign hw1 = (ang_q >= TwoPiQ) ? ang_q - TwoPiQ :
               (ang_q <= -TwoPiQ) ? ang_q + TwoPiQ : ang_q;
  assign hw2 = (hw1 > PiQ) ? hw1 - TwoPiQ : (hw1 < -PiQ) ? hw1 + TwoPiQ : hw1;
  assign afold = (ang_q > HalfPiQ) ? ang_q - PiQ :
                 (ang_q < -HalfPiQ) ? ang_q + PiQ : ang_q;

  // CORDIC
  logic cstart, cdone;
  logic signed [33:0] ccos, csin;
  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .angle_i(afold),
    .done_o(cdone), .cos_o(ccos), .sin_o(csin));

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:    if (in_valid_i && in_ready_o) st_d = ST_DELTA;
      ST_DELTA:   st_d = ST_SCALE_L;
      ST_SCALE_L: if (mph_q) st_d = ST_SCALE_R;
      ST_SCALE_R: if (mph_q) st_d = ST_DIST;
      ST_DIST:    st_d = ST_TURN;
      ST_TURN:    if (mph_q) st_d = ST_HEAD;
      ST_HEAD:    st_d = ST_WRAP;
      ST_WRAP:    st_d = ST_FOLD;
      ST_FOLD:    st_d = ST_CORDIC;
      ST_CORDIC:  if (cdone) st_d = ST_MUL_C;
      ST_MUL_C:   if (mph_q) st_d = ST_MUL_S;
      ST_MUL_S:   if (mph_q) st_d = ST_ACC;
      ST_ACC:     st_d = ST_OUT;
      ST_OUT:     if (!ovalid_q) st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = (st_q == ST_IDLE) && !ovalid_q;
    cstart = (st_q == ST_FOLD);
  end

  logic signed [PW+1:0] ny, nx;
  logic signed [PW+1:0] pmax, pmin;
  assign pmax = (PW+2)'((PW+2)'(1) <<< (PW-1)) - (PW+2)'(1);
  assign pmin = -pmax - (PW+2)'(1);
  assign mhsat = mres;
  assign hsum = 34'(head_q) + 34'(chg_q);
  assign ny = (PW+2)'(y_q) + dy_q;
  assign nx = (PW+2)'(x_q) + dx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; first_q <= 1'b1; lastl_q <= '0; lastr_q <= '0;
      head_q <= '0; x_q <= '0; y_q <= '0; ovalid_q <= 1'b0; mph_q <= 1'b0;
    end else begin
      st_q <= st_d;
      mph_q <= mul_on & ~mph_q;
      if (mul_on && !mph_q) plo_q <= mp;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (st_q)
        ST_IDLE: if (in_valid_i && in_ready_o) begin
          if (first_q) begin
            lastl_q <= in_i.left_count; lastr_q <= in_i.right_count;
            first_q <= 1'b0;
          end
          ang_q <= {18'd0, in_i.left_count}; cos_q <= {18'd0, in_i.right_count};
        end
        ST_DELTA: begin
          lt_q <= 17'($signed(16'(ang_q[15:0] - lastl_q)));
          rt_q <= 17'($signed(16'(cos_q[15:0] - lastr_q)));
          lastl_q <= ang_q[15:0]; lastr_q <= cos_q[15:0];
        end
        ST_SCALE_L: begin
          if (mph_q) li_q <= 42'(mres);
          flag_q <= (lt_q > $signed({2'd0, tlim_q})) || (rt_q > $signed({2'd0, tlim_q}));
        end
        ST_SCALE_R: if (mph_q) ri_q <= 42'(mres);
        ST_DIST: dist_q <= (li_q + ri_q) >>> 1;
        ST_TURN: if (mph_q) begin
          if (mhsat > 77'sd2147483647) chg_q <= 32'sh7FFFFFFF;
          else if (mhsat < -77'sd2147483648) chg_q <= 32'sh80000000;
          else chg_q <= 32'(mhsat);
        end
        ST_HEAD: begin
          // wrap toward zero: |sum| < 2^32 so at most two subtractions
          if (hsum >= TwoPiQ) ang_q <= hsum - TwoPiQ;
          else if (hsum <= -TwoPiQ) ang_q <= hsum + TwoPiQ;
          else ang_q <= hsum;
        end
        ST_WRAP: begin
          head_q <= 32'(hw1);
          ang_q <= hw2;
        end
        ST_FOLD: begin
          neg_q <= 1'b0;
          if (ang_q > HalfPiQ) begin ang_q <= ang_q - PiQ; neg_q <= 1'b1; end
          else if (ang_q < -HalfPiQ) begin ang_q <= ang_q + PiQ; neg_q <= 1'b1; end
        end
        ST_CORDIC: if (cdone) begin
          cos_q <= neg_q ? -ccos : ccos;
          sin_q <= neg_q ? -csin : csin;
        end
        ST_MUL_C: if (mph_q) dy_q <= (PW+2)'(mres);
        ST_MUL_S: if (mph_q) dx_q <= (PW+2)'(mres);
        ST_ACC: begin
          y_q <= (ny > pmax) ? PW'(pmax) : (ny < pmin) ? PW'(pmin) : PW'(ny);
          x_q <= (nx > pmax) ? PW'(pmax) : (nx < pmin) ? PW'(pmin) : PW'(nx);
          ovalid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_o = '{x_position: x_q, y_position: y_q, heading: head_q,
                   heading_change: chg_q, ticks_implausible: flag_q};
endmodule

>>> hdl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ddo_cordic #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  import ddo_pkg::*;

  localparam int unsigned Steps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;

  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [4:0] i_q, i_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [33:0] xs, ys;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;

  // one rotation step
  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      x_d = CordicGainQ; y_d = '0; z_d = angle_i; i_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - atan_lut(i_q);
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + atan_lut(i_q);
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(Steps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; i_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;
endmodule

>>> hdl/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks on the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "differential_drive_odometry_assert.svh"
module ddo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ddo_pkg::out_item_t out_o,
  input logic               pready
);
  `DDO_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)
  `DDO_ASSERT_IMP(a_busy_out, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `DDO_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o)
  `DDO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o))
endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);
